FILE: sv/pzgt_pkg.sv
// Shared types and constants of the position-zone gesture tracker.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps
`default_nettype none

package pzgt_pkg;

  localparam int COORD_BITS  = 12;
  localparam int COUNT_BITS  = 8;
  localparam int LEVEL_BITS  = 10;
  localparam int DEB_BITS    = 16;
  localparam int KIND_BITS   = 2;
  localparam int BUTTON_BITS = 2;
  localparam int MODE_BITS   = 3;

  // multiply-then-divide operand widths
  localparam int PROD_BITS   = LEVEL_BITS + COORD_BITS;
  localparam int STEP_BITS   = $clog2(PROD_BITS);

  // configuration port
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_REGS      = 8;
  localparam int CFG_IDX_BITS  = $clog2(CFG_REGS);
  localparam int CFG_ADDR_BITS = CFG_IDX_BITS + 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_LEFT_ZONE   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_BUTTON_LINE = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_LEVEL_LOW   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_LEVEL_HIGH  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_LEVEL_SPAN  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMG_WIDTH   = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_LEVEL_STEPS = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE    = 3'd7;

  // tracker modes
  localparam logic [MODE_BITS-1:0] MODE_NONE     = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_UNARMED  = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_ARMED    = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_DEBOUNCE = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_EXPR     = 3'd4;

  // event kinds
  localparam logic [KIND_BITS-1:0] EV_NONE   = 2'd0;
  localparam logic [KIND_BITS-1:0] EV_BUTTON = 2'd1;
  localparam logic [KIND_BITS-1:0] EV_LEVEL  = 2'd2;

  localparam logic [BUTTON_BITS-1:0] BTN_NONE  = 2'd0;
  localparam logic [BUTTON_BITS-1:0] BTN_ONE   = 2'd1;
  localparam logic [BUTTON_BITS-1:0] BTN_TWO   = 2'd2;
  localparam logic [BUTTON_BITS-1:0] BTN_THREE = 2'd3;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

FILE: sv/pzgt_if.sv
// Valid/ready channel interfaces for frame reports and tracker results.
// Depends on pzgt_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface pzgt_in_if;
  logic                             valid;
  logic                             ready;
  logic [pzgt_pkg::COUNT_BITS-1:0]  object_count;
  logic [pzgt_pkg::COORD_BITS-1:0]  pos_x;
  logic [pzgt_pkg::COORD_BITS-1:0]  pos_y;

  modport source (output valid, output object_count, output pos_x, output pos_y,
                  input ready);
  modport sink   (input valid, input object_count, input pos_x, input pos_y,
                  output ready);
endinterface

interface pzgt_out_if;
  logic                              valid;
  logic                              ready;
  logic [pzgt_pkg::KIND_BITS-1:0]    event_kind;
  logic [pzgt_pkg::BUTTON_BITS-1:0]  button_number;
  logic [pzgt_pkg::LEVEL_BITS-1:0]   level_value;
  logic [pzgt_pkg::MODE_BITS-1:0]    tracker_mode;

  modport source (output valid, output event_kind, output button_number,
                  output level_value, output tracker_mode, input ready);
  modport sink   (input valid, input event_kind, input button_number,
                  input level_value, input tracker_mode, output ready);
endinterface

`default_nettype wire

FILE: sv/pzgt_div.sv
// Multiply-then-divide unit: (a * b) / divisor, one restoring step a cycle.
// Depends on pzgt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pzgt_div (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic [pzgt_pkg::LEVEL_BITS-1:0]  mul_a,
  input  wire logic [pzgt_pkg::COORD_BITS-1:0]  mul_b,
  input  wire logic [pzgt_pkg::COORD_BITS-1:0]  divisor,
  output pzgt_pkg::div_stat_t                   stat,
  output logic      [pzgt_pkg::LEVEL_BITS-1:0]  quotient
);

  localparam int PB = pzgt_pkg::PROD_BITS;
  localparam int CB = pzgt_pkg::COORD_BITS;
  localparam int SB = pzgt_pkg::STEP_BITS;
  localparam logic [SB-1:0] LAST_STEP = SB'(PB - 1);

  logic          run_r, run_nxt;
  logic          done_r, done_nxt;
  logic [SB-1:0] cnt_r, cnt_nxt;
  logic [CB-1:0] rem_r, rem_nxt;
  logic [PB-1:0] q_r, q_nxt;

  logic [CB:0]   rem_sh;
  logic [CB:0]   diff;

  // partial remainder stays below the divisor, so CB+1 bits cover the shift
  assign rem_sh = {rem_r, q_r[PB-1]};
  assign diff   = rem_sh - {1'b0, divisor};

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    if (start) begin
      q_nxt   = PB'(mul_a) * PB'(mul_b);
      rem_nxt = '0;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (rem_sh >= {1'b0, divisor}) begin
        rem_nxt = diff[CB-1:0];
        q_nxt   = {q_r[PB-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[CB-1:0];
        q_nxt   = {q_r[PB-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_STEP) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  // quotient never exceeds mul_a, so the low bits hold all of it
  assign quotient  = q_r[pzgt_pkg::LEVEL_BITS-1:0];
  assign stat.busy = run_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

FILE: sv/position_zone_gesture_tracker.sv
// Top level of the position-zone gesture tracker: registers, tracker FSM, output word.
// Depends on pzgt_pkg, pzgt_if and pzgt_div.
`timescale 1ns / 1ps
`default_nettype none

// One frame report goes in per word and exactly one result word comes out for it.
// The tracker (no track, unarmed, armed, debouncing, expression) and the debounce
// countdown update when the report is accepted. A frame that keeps expression mode
// and whose y lies from level_low up to level_high and below level_low plus level_span
// goes to the divider: the level is level_steps times the remaining span, divided by
// level_span, worked out by the multiply and restoring divider unit, one quotient bit
// a cycle over 22 bits. in_if.ready is high only while the sequencer is idle; the
// output register lets the next report in while a result still waits, and a frame
// finishing behind a waiting result holds the sequencer until that word is taken.
// Registers sit at byte addresses 4*i on the APB port; the user must write them only
// while no frame is in flight, as the block itself does not enforce this.

module position_zone_gesture_tracker (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  pzgt_in_if.sink                                   in_if,
  pzgt_out_if.source                                out_if,
  input  wire logic                                 cfg_psel,
  input  wire logic                                 cfg_penable,
  input  wire logic                                 cfg_pwrite,
  input  wire logic [pzgt_pkg::CFG_ADDR_BITS-1:0]   cfg_paddr,
  input  wire logic [pzgt_pkg::CFG_DATA_BITS-1:0]   cfg_pwdata,
  output logic      [pzgt_pkg::CFG_DATA_BITS-1:0]   cfg_prdata,
  output logic                                      cfg_pready
);

  localparam int CB = pzgt_pkg::COORD_BITS;
  localparam int LB = pzgt_pkg::LEVEL_BITS;
  localparam int DB = pzgt_pkg::DEB_BITS;
  localparam int MB = pzgt_pkg::MODE_BITS;
  localparam int KB = pzgt_pkg::KIND_BITS;
  localparam int BB = pzgt_pkg::BUTTON_BITS;
  localparam int WB = pzgt_pkg::CFG_DATA_BITS;

  // sequencer
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_START = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  // ---------------- configuration registers ----------------
  logic [CB-1:0] left_zone_r, button_line_r, level_low_r, level_high_r;
  logic [CB-1:0] level_span_r, img_width_r;
  logic [LB-1:0] level_steps_r;
  logic [DB-1:0] debounce_frames_r;

  logic                               cfg_wr;
  logic [pzgt_pkg::CFG_IDX_BITS-1:0]  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[pzgt_pkg::CFG_ADDR_BITS-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_zone_r       <= '0;
      button_line_r     <= '0;
      level_low_r       <= '0;
      level_high_r      <= '0;
      level_span_r      <= CB'(1);
      img_width_r       <= CB'(640);
      level_steps_r     <= LB'(127);
      debounce_frames_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        pzgt_pkg::REG_LEFT_ZONE:   left_zone_r       <= cfg_pwdata[CB-1:0];
        pzgt_pkg::REG_BUTTON_LINE: button_line_r     <= cfg_pwdata[CB-1:0];
        pzgt_pkg::REG_LEVEL_LOW:   level_low_r       <= cfg_pwdata[CB-1:0];
        pzgt_pkg::REG_LEVEL_HIGH:  level_high_r      <= cfg_pwdata[CB-1:0];
        pzgt_pkg::REG_LEVEL_SPAN:  level_span_r      <= cfg_pwdata[CB-1:0];
        pzgt_pkg::REG_IMG_WIDTH:   img_width_r       <= cfg_pwdata[CB-1:0];
        pzgt_pkg::REG_LEVEL_STEPS: level_steps_r     <= cfg_pwdata[LB-1:0];
        pzgt_pkg::REG_DEBOUNCE:    debounce_frames_r <= cfg_pwdata[DB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      pzgt_pkg::REG_LEFT_ZONE:   cfg_prdata = WB'(left_zone_r);
      pzgt_pkg::REG_BUTTON_LINE: cfg_prdata = WB'(button_line_r);
      pzgt_pkg::REG_LEVEL_LOW:   cfg_prdata = WB'(level_low_r);
      pzgt_pkg::REG_LEVEL_HIGH:  cfg_prdata = WB'(level_high_r);
      pzgt_pkg::REG_LEVEL_SPAN:  cfg_prdata = WB'(level_span_r);
      pzgt_pkg::REG_IMG_WIDTH:   cfg_prdata = WB'(img_width_r);
      pzgt_pkg::REG_LEVEL_STEPS: cfg_prdata = WB'(level_steps_r);
      pzgt_pkg::REG_DEBOUNCE:    cfg_prdata = WB'(debounce_frames_r);
      default:                   cfg_prdata = '0;
    endcase
  end

  // ---------------- tracker ----------------
  logic [1:0]    seq_r, seq_nxt;
  logic [MB-1:0] mode_r, mode_nxt;
  logic [DB-1:0] deb_cnt_r, deb_cnt_nxt;
  logic [KB-1:0] res_kind_r, res_kind_nxt;
  logic [BB-1:0] res_button_r, res_button_nxt;
  logic [LB-1:0] res_level_r, res_level_nxt;
  logic [CB-1:0] span_rem_r, span_rem_nxt;

  logic          accept;
  logic          need_div;
  logic [DB-1:0] deb_dec;
  logic [CB-1:0] x, y, d, half_w, three_q_w;
  logic [CB+1:0] three_w;

  pzgt_pkg::div_stat_t div_stat;
  logic [LB-1:0]       div_q;

  // output register
  logic          out_valid_r;
  logic [KB-1:0] out_kind_r;
  logic [BB-1:0] out_button_r;
  logic [LB-1:0] out_level_r;
  logic [MB-1:0] out_mode_r;
  logic          out_load;

  assign in_if.ready = (seq_r == S_IDLE);
  assign accept      = in_if.valid && in_if.ready;
  assign x           = in_if.pos_x;
  assign y           = in_if.pos_y;
  assign d           = y - level_low_r;
  assign deb_dec     = (deb_cnt_r == '0) ? deb_cnt_r : deb_cnt_r - 1'b1;
  // (2*w)/4 is w/2; (3*w)/4 via the widened sum
  assign half_w      = {1'b0, img_width_r[CB-1:1]};
  assign three_w     = {2'b00, img_width_r} + {1'b0, img_width_r, 1'b0};
  assign three_q_w   = three_w[CB+1:2];

  always_comb begin
    seq_nxt        = seq_r;
    mode_nxt       = mode_r;
    deb_cnt_nxt    = deb_cnt_r;
    res_kind_nxt   = res_kind_r;
    res_button_nxt = res_button_r;
    res_level_nxt  = res_level_r;
    span_rem_nxt   = span_rem_r;
    need_div       = 1'b0;
    out_load       = 1'b0;
    case (seq_r)
      S_IDLE: begin
        if (accept) begin
          deb_cnt_nxt    = deb_dec;
          res_kind_nxt   = pzgt_pkg::EV_NONE;
          res_button_nxt = pzgt_pkg::BTN_NONE;
          res_level_nxt  = '0;
          if (in_if.object_count == pzgt_pkg::COUNT_BITS'(1)) begin
            case (mode_r)
              pzgt_pkg::MODE_NONE, pzgt_pkg::MODE_UNARMED: begin
                if (x < left_zone_r)        mode_nxt = pzgt_pkg::MODE_EXPR;
                else if (y < button_line_r) mode_nxt = pzgt_pkg::MODE_ARMED;
                else                        mode_nxt = pzgt_pkg::MODE_UNARMED;
              end
              pzgt_pkg::MODE_ARMED: begin
                if (x < left_zone_r) begin
                  mode_nxt = pzgt_pkg::MODE_EXPR;
                end else if (y > button_line_r) begin
                  mode_nxt     = pzgt_pkg::MODE_DEBOUNCE;
                  deb_cnt_nxt  = debounce_frames_r;
                  res_kind_nxt = pzgt_pkg::EV_BUTTON;
                  if (x < half_w)         res_button_nxt = pzgt_pkg::BTN_ONE;
                  else if (x < three_q_w) res_button_nxt = pzgt_pkg::BTN_TWO;
                  else                    res_button_nxt = pzgt_pkg::BTN_THREE;
                end
              end
              pzgt_pkg::MODE_DEBOUNCE: begin
                if (deb_dec == '0) mode_nxt = pzgt_pkg::MODE_UNARMED;
              end
              pzgt_pkg::MODE_EXPR: begin
                if (x > left_zone_r) begin
                  mode_nxt = pzgt_pkg::MODE_UNARMED;
                end else begin
                  res_kind_nxt = pzgt_pkg::EV_LEVEL;
                  if (y > level_high_r) begin
                    res_level_nxt = '0;
                  end else if (y < level_low_r) begin
                    res_level_nxt = level_steps_r;
                  end else if (d >= level_span_r) begin
                    // also covers a zero span
                    res_level_nxt = '0;
                  end else begin
                    need_div     = 1'b1;
                    span_rem_nxt = level_span_r - d;
                  end
                end
              end
              default: ;
            endcase
          end else if (mode_r != pzgt_pkg::MODE_DEBOUNCE) begin
            mode_nxt = pzgt_pkg::MODE_NONE;
          end
          seq_nxt = need_div ? S_START : S_OUT;
        end
      end
      S_START: seq_nxt = S_WAIT;
      S_WAIT: begin
        if (div_stat.done) begin
          res_level_nxt = div_q;
          seq_nxt       = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_if.ready) begin
          out_load = 1'b1;
          seq_nxt  = S_IDLE;
        end
      end
      default: seq_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r     <= S_IDLE;
      mode_r    <= pzgt_pkg::MODE_NONE;
      deb_cnt_r <= '0;
    end else begin
      seq_r     <= seq_nxt;
      mode_r    <= mode_nxt;
      deb_cnt_r <= deb_cnt_nxt;
    end
    res_kind_r   <= res_kind_nxt;
    res_button_r <= res_button_nxt;
    res_level_r  <= res_level_nxt;
    span_rem_r   <= span_rem_nxt;
  end

  pzgt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (seq_r == S_START),
    .mul_a    (level_steps_r),
    .mul_b    (span_rem_r),
    .divisor  (level_span_r),
    .stat     (div_stat),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_kind_r   <= res_kind_r;
      out_button_r <= res_button_r;
      out_level_r  <= res_level_r;
      out_mode_r   <= mode_r;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.event_kind    = out_kind_r;
  assign out_if.button_number = out_button_r;
  assign out_if.level_value   = out_level_r;
  assign out_if.tracker_mode  = out_mode_r;

endmodule

`default_nettype wire

FILE: sv/pzgt_checker.sv
// Port-level checks of the gesture tracker, bound to the top level.
// Depends on pzgt_pkg and position_zone_gesture_tracker.
`timescale 1ns / 1ps
`default_nettype none

module pzgt_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_valid,
  input wire logic                               in_ready,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic [pzgt_pkg::KIND_BITS-1:0]     event_kind,
  input wire logic [pzgt_pkg::BUTTON_BITS-1:0]   button_number,
  input wire logic [pzgt_pkg::LEVEL_BITS-1:0]    level_value,
  input wire logic [pzgt_pkg::MODE_BITS-1:0]     tracker_mode
);

  // a press always lands in debounce with a real button and a zero level
  a_press_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && event_kind == pzgt_pkg::EV_BUTTON |->
      tracker_mode == pzgt_pkg::MODE_DEBOUNCE && button_number != pzgt_pkg::BTN_NONE
      && level_value == '0)
    else $error("button word with wrong mode or fields");

  a_level_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && event_kind == pzgt_pkg::EV_LEVEL |->
      tracker_mode == pzgt_pkg::MODE_EXPR && button_number == pzgt_pkg::BTN_NONE)
    else $error("level word outside expression mode");

  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && event_kind == pzgt_pkg::EV_NONE |->
      button_number == pzgt_pkg::BTN_NONE && level_value == '0)
    else $error("empty word carries data");

  // one frame at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accept");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(event_kind)
      && $stable(button_number) && $stable(level_value) && $stable(tracker_mode))
    else $error("stalled result word changed");

endmodule

bind position_zone_gesture_tracker pzgt_checker u_pzgt_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_if.valid),
  .in_ready      (in_if.ready),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .event_kind    (out_if.event_kind),
  .button_number (out_if.button_number),
  .level_value   (out_if.level_value),
  .tracker_mode  (out_if.tracker_mode)
);

`default_nettype wire

FILE: tb/tb_position_zone_gesture_tracker.sv
// Self-checking testbench for position_zone_gesture_tracker: frame reports in, tracker words out.
// Depends on pzgt_pkg, pzgt_if and the top level; a predictor or a typed row checks each word.
`timescale 1ns / 1ps

module tb_position_zone_gesture_tracker;
  import pzgt_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int DIR_ROWS    = 25;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 136;
  // settle for longer than the slowest frame takes
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 1500000;
  localparam int COORD_MAX     = (1 << COORD_BITS) - 1;

  typedef struct packed {
    logic [KIND_BITS-1:0]   kind;
    logic [BUTTON_BITS-1:0] button;
    logic [LEVEL_BITS-1:0]  level;
    logic [MODE_BITS-1:0]   mode;
  } tracker_result_t;

  typedef struct {
    logic [COORD_BITS-1:0] left_zone;
    logic [COORD_BITS-1:0] button_line;
    logic [COORD_BITS-1:0] level_low;
    logic [COORD_BITS-1:0] level_high;
    logic [COORD_BITS-1:0] level_span;
    logic [COORD_BITS-1:0] img_width;
    logic [LEVEL_BITS-1:0] level_steps;
    logic [DEB_BITS-1:0]   debounce;
  } tracker_regs_t;

  typedef struct {
    logic [COUNT_BITS-1:0] cnt;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    bit                    typed;
    tracker_result_t       res;
  } frame_row_t;

  logic clk;
  logic rst_n;
  logic                     cfg_psel;
  logic                     cfg_penable;
  logic                     cfg_pwrite;
  logic [CFG_ADDR_BITS-1:0] cfg_paddr;
  logic [CFG_DATA_BITS-1:0] cfg_pwdata;
  logic [CFG_DATA_BITS-1:0] cfg_prdata;
  logic                     cfg_pready;

  pzgt_in_if  in_if ();
  pzgt_out_if out_if ();

  position_zone_gesture_tracker u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_if),
    .out_if      (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // tracker predictor state
  tracker_regs_t          tracker_regs;
  logic [MODE_BITS-1:0]   trk_mode;
  logic [DEB_BITS-1:0]    deb_left;
  tracker_result_t        pending_results [$];

  int  errors = 0;
  int  cycle_count = 0;
  bit  calm = 1'b0;

  // directed frames, run under left 100, button line 2000, levels 500..1500 / span 1000,
  // width 640, 127 steps, debounce 2
  frame_row_t dir_rows [DIR_ROWS] = '{
    '{8'd0,   12'd4095, 12'd4095, 1'b1, '{EV_NONE, BTN_NONE, 10'd0, MODE_NONE}},
    '{8'd255, 12'd0,    12'd0,    1'b1, '{EV_NONE, BTN_NONE, 10'd0, MODE_NONE}},
    '{8'd1,   12'd200,  12'd3000, 1'b1, '{EV_NONE, BTN_NONE, 10'd0, MODE_UNARMED}},
    '{8'd1,   12'd200,  12'd1000, 1'b1, '{EV_NONE, BTN_NONE, 10'd0, MODE_ARMED}},
    // y right on the button line: no press, no disarm
    '{8'd1,   12'd200,  12'd2000, 1'b1, '{EV_NONE, BTN_NONE, 10'd0, MODE_ARMED}},
    '{8'd1,   12'd200,  12'd2001, 1'b1, '{EV_BUTTON, BTN_ONE, 10'd0, MODE_DEBOUNCE}},
    '{8'd1,   12'd0,    12'd0,    1'b0, '0},
    '{8'd0,   12'd0,    12'd0,    1'b0, '0},
    '{8'd1,   12'd500,  12'd0,    1'b0, '0},
    '{8'd1,   12'd4095, 12'd0,    1'b0, '0},
    '{8'd1,   12'd4095, 12'd4095, 1'b1, '{EV_BUTTON, BTN_THREE, 10'd0, MODE_DEBOUNCE}},
    '{8'd3,   12'd0,    12'd0,    1'b0, '0},
    '{8'd1,   12'd400,  12'd100,  1'b0, '0},
    '{8'd1,   12'd400,  12'd100,  1'b0, '0},
    '{8'd1,   12'd400,  12'd3000, 1'b0, '0},
    '{8'd1,   12'd400,  12'd100,  1'b0, '0},
    '{8'd1,   12'd400,  12'd100,  1'b0, '0},
    '{8'd1,   12'd400,  12'd100,  1'b0, '0},
    '{8'd1,   12'd99,   12'd0,    1'b0, '0},
    // x on the left limit keeps expression mode
    '{8'd1,   12'd100,  12'd0,    1'b1, '{EV_LEVEL, BTN_NONE, 10'd127, MODE_EXPR}},
    '{8'd1,   12'd0,    12'd4095, 1'b1, '{EV_LEVEL, BTN_NONE, 10'd0, MODE_EXPR}},
    '{8'd1,   12'd50,   12'd1000, 1'b0, '0},
    '{8'd1,   12'd50,   12'd1500, 1'b0, '0},
    '{8'd1,   12'd101,  12'd700,  1'b0, '0},
    '{8'd2,   12'd4095, 12'd4095, 1'b0, '0}
  };

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL position_zone_gesture_tracker");
      $finish;
    end
  end

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [LEVEL_BITS-1:0] expr_level(input logic [COORD_BITS-1:0] y);
    int unsigned d;
    int unsigned span;
    int unsigned steps;
    span  = tracker_regs.level_span;
    steps = tracker_regs.level_steps;
    if (y > tracker_regs.level_high) return '0;
    if (y < tracker_regs.level_low) return tracker_regs.level_steps;
    d = y - tracker_regs.level_low;
    if (span == 0 || d >= span) return '0;
    return LEVEL_BITS'((steps * (span - d)) / span);
  endfunction

  // advances the tracker by one frame and returns the word it should produce
  function automatic tracker_result_t track_frame(input logic [COUNT_BITS-1:0] cnt,
                                                  input logic [COORD_BITS-1:0] x,
                                                  input logic [COORD_BITS-1:0] y);
    tracker_result_t r;
    int unsigned     fw;
    r  = '0;
    fw = tracker_regs.img_width;
    if (deb_left != 0) deb_left = deb_left - 1'b1;
    if (cnt == 1) begin
      case (trk_mode)
        MODE_NONE, MODE_UNARMED: begin
          if (x < tracker_regs.left_zone) trk_mode = MODE_EXPR;
          else if (y < tracker_regs.button_line) trk_mode = MODE_ARMED;
          else trk_mode = MODE_UNARMED;
        end
        MODE_ARMED: begin
          if (x < tracker_regs.left_zone) begin
            trk_mode = MODE_EXPR;
          end else if (y > tracker_regs.button_line) begin
            trk_mode = MODE_DEBOUNCE;
            deb_left = tracker_regs.debounce;
            r.kind   = EV_BUTTON;
            if (x < (2 * fw) / 4) r.button = BTN_ONE;
            else if (x < (3 * fw) / 4) r.button = BTN_TWO;
            else r.button = BTN_THREE;
          end
        end
        MODE_DEBOUNCE: begin
          if (deb_left == 0) trk_mode = MODE_UNARMED;
        end
        MODE_EXPR: begin
          if (x > tracker_regs.left_zone) begin
            trk_mode = MODE_UNARMED;
          end else begin
            r.kind  = EV_LEVEL;
            r.level = expr_level(y);
          end
        end
        default: ;
      endcase
    end else if (trk_mode != MODE_DEBOUNCE) begin
      trk_mode = MODE_NONE;
    end
    r.mode = trk_mode;
    return r;
  endfunction

  always @(posedge clk) begin : check_results
    tracker_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: kind %0d mode %0d",
               out_if.event_kind, out_if.tracker_mode);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_if.event_kind !== want.kind) begin
          $error("event_kind: expected %0d, got %0d", want.kind, out_if.event_kind);
          errors++;
        end
        if (out_if.button_number !== want.button) begin
          $error("button_number: expected %0d, got %0d", want.button, out_if.button_number);
          errors++;
        end
        if (out_if.level_value !== want.level) begin
          $error("level_value: expected %0d, got %0d", want.level, out_if.level_value);
          errors++;
        end
        if (out_if.tracker_mode !== want.mode) begin
          $error("tracker_mode: expected %0d, got %0d", want.mode, out_if.tracker_mode);
          errors++;
        end
      end
    end
  end

  initial begin : result_ready
    int hold;
    hold = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_if.ready <= 1'b0;
        hold--;
      end else begin
        out_if.ready <= 1'b1;
        if (!calm && $urandom_range(0, 2) == 0) hold = idle_gap();
      end
    end
  end

  // write then read back one register; the predictor copy follows the write
  task automatic cfg_set(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] val);
    logic [31:0] kept;
    kept = '0;
    case (idx)
      REG_LEFT_ZONE:   begin tracker_regs.left_zone   = val[11:0]; kept[11:0] = val[11:0]; end
      REG_BUTTON_LINE: begin tracker_regs.button_line = val[11:0]; kept[11:0] = val[11:0]; end
      REG_LEVEL_LOW:   begin tracker_regs.level_low   = val[11:0]; kept[11:0] = val[11:0]; end
      REG_LEVEL_HIGH:  begin tracker_regs.level_high  = val[11:0]; kept[11:0] = val[11:0]; end
      REG_LEVEL_SPAN:  begin tracker_regs.level_span  = val[11:0]; kept[11:0] = val[11:0]; end
      REG_IMG_WIDTH:   begin tracker_regs.img_width   = val[11:0]; kept[11:0] = val[11:0]; end
      REG_LEVEL_STEPS: begin tracker_regs.level_steps = val[9:0];  kept[9:0]  = val[9:0];  end
      REG_DEBOUNCE:    begin tracker_regs.debounce    = val[15:0]; kept[15:0] = val[15:0]; end
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== kept) begin
      $error("cfg_prdata reg %0d: expected %0h, got %0h", idx, kept, cfg_prdata);
      errors++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic load_regs(input tracker_regs_t c);
    cfg_set(REG_LEFT_ZONE,   32'(c.left_zone));
    cfg_set(REG_BUTTON_LINE, 32'(c.button_line));
    cfg_set(REG_LEVEL_LOW,   32'(c.level_low));
    cfg_set(REG_LEVEL_HIGH,  32'(c.level_high));
    cfg_set(REG_LEVEL_SPAN,  32'(c.level_span));
    cfg_set(REG_IMG_WIDTH,   32'(c.img_width));
    cfg_set(REG_LEVEL_STEPS, 32'(c.level_steps));
    cfg_set(REG_DEBOUNCE,    32'(c.debounce));
  endtask

  task automatic send_frame(input logic [COUNT_BITS-1:0] cnt,
                            input logic [COORD_BITS-1:0] x,
                            input logic [COORD_BITS-1:0] y,
                            input bit                    typed = 1'b0,
                            input tracker_result_t       typed_res = '0);
    int              gap;
    tracker_result_t pred;
    gap = calm ? 0 : idle_gap();
    repeat (gap) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
    end
    @(negedge clk);
    in_if.valid        <= 1'b1;
    in_if.object_count <= cnt;
    in_if.pos_x        <= x;
    in_if.pos_y        <= y;
    do @(posedge clk); while (!in_if.ready);
    pred = track_frame(cnt, x, y);
    pending_results.push_back(typed ? typed_res : pred);
  endtask

  // sender holds off until every result word is back and the block is quiet
  task automatic settle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [COORD_BITS-1:0] clamp_coord(input int v);
    if (v < 0) return '0;
    if (v > COORD_MAX) return COORD_BITS'(COORD_MAX);
    return COORD_BITS'(v);
  endfunction

  function automatic logic [COORD_BITS-1:0] near(input int c, input int s);
    return clamp_coord(c - s + int'($urandom_range(0, 2 * s)));
  endfunction

  function automatic logic [COORD_BITS-1:0] rand_coord();
    return COORD_BITS'($urandom_range(0, COORD_MAX));
  endfunction

  // strictly below lim, often right next to it; 0 when lim is 0 or less
  function automatic logic [COORD_BITS-1:0] pick_below(input int lim);
    if (lim <= 0) return '0;
    if ($urandom_range(0, 1) != 0)
      return COORD_BITS'($urandom_range(lim > 3 ? lim - 3 : 0, lim - 1));
    return COORD_BITS'($urandom_range(0, lim - 1));
  endfunction

  // strictly above lim, often right next to it; COORD_MAX when lim is COORD_MAX or more
  function automatic logic [COORD_BITS-1:0] pick_above(input int lim);
    if (lim >= COORD_MAX) return COORD_BITS'(COORD_MAX);
    if ($urandom_range(0, 1) != 0)
      return COORD_BITS'($urandom_range(lim + 1, lim + 3 > COORD_MAX ? COORD_MAX : lim + 3));
    return COORD_BITS'($urandom_range(lim + 1, COORD_MAX));
  endfunction

  // x outside the expression zone, weighted toward the button boundaries
  function automatic logic [COORD_BITS-1:0] x_right();
    logic [COORD_BITS-1:0] x;
    int                    fw;
    fw = tracker_regs.img_width;
    case ($urandom_range(0, 4))
      0: x = near((2 * fw) / 4, 2);
      1: x = near((3 * fw) / 4, 2);
      2: x = COORD_BITS'(COORD_MAX);
      3: x = near(tracker_regs.left_zone, 2);
      default: x = rand_coord();
    endcase
    if (x < tracker_regs.left_zone) x = tracker_regs.left_zone;
    return x;
  endfunction

  function automatic logic [COORD_BITS-1:0] y_level();
    int lo;
    lo = tracker_regs.level_low;
    case ($urandom_range(0, 5))
      0: return near(lo, 2);
      1: return near(tracker_regs.level_high, 2);
      2: return near(lo + int'(tracker_regs.level_span), 2);
      3: return '0;
      4: return COORD_BITS'(COORD_MAX);
      default: return rand_coord();
    endcase
  endfunction

  function automatic logic [COUNT_BITS-1:0] other_count();
    if ($urandom_range(0, 3) == 0) return '0;
    return COUNT_BITS'($urandom_range(2, 255));
  endfunction

  // one gesture: a press, a stay in the expression zone, a dropout or plain noise
  task automatic play_gesture(output int n);
    int                    pick;
    int                    reps;
    logic [COORD_BITS-1:0] xs;
    n    = 0;
    pick = $urandom_range(0, 9);
    if (pick <= 3) begin
      reps = $urandom_range(1, 3);
      repeat (reps) begin
        send_frame(8'd1, x_right(), pick_below(tracker_regs.button_line));
        n++;
      end
      if ($urandom_range(0, 3) == 0) begin
        send_frame(8'd1, x_right(), tracker_regs.button_line);
        n++;
      end
      send_frame(8'd1, x_right(), pick_above(tracker_regs.button_line));
      n++;
      reps = $urandom_range(0, 6);
      repeat (reps) begin
        send_frame($urandom_range(0, 4) == 0 ? other_count() : 8'd1, rand_coord(), rand_coord());
        n++;
      end
    end else if (pick <= 6) begin
      send_frame(8'd1, pick_below(tracker_regs.left_zone), y_level());
      n++;
      reps = $urandom_range(2, 8);
      repeat (reps) begin
        if ($urandom_range(0, 3) == 0) xs = tracker_regs.left_zone;
        else xs = COORD_BITS'($urandom_range(0, tracker_regs.left_zone));
        send_frame(8'd1, xs, y_level());
        n++;
      end
      if ($urandom_range(0, 1) != 0) begin
        send_frame(8'd1, pick_above(tracker_regs.left_zone), y_level());
        n++;
      end
    end else if (pick == 7) begin
      reps = $urandom_range(1, 3);
      repeat (reps) begin
        send_frame(other_count(), rand_coord(), rand_coord());
        n++;
      end
    end else begin
      reps = $urandom_range(1, 4);
      repeat (reps) begin
        send_frame($urandom_range(0, 2) == 0 ? COUNT_BITS'($urandom_range(0, 255)) : 8'd1,
                   rand_coord(), rand_coord());
        n++;
      end
    end
  endtask

  function automatic tracker_regs_t rand_regs();
    tracker_regs_t c;
    int            r;
    c.left_zone   = rand_coord();
    c.button_line = rand_coord();
    c.level_low   = COORD_BITS'($urandom_range(0, 2047));
    c.level_high  = COORD_BITS'(int'(c.level_low) + int'($urandom_range(0, COORD_MAX - c.level_low)));
    if ($urandom_range(0, 3) != 0) c.level_span = c.level_high - c.level_low;
    else c.level_span = COORD_BITS'($urandom_range(1, COORD_MAX));
    c.img_width   = COORD_BITS'($urandom_range(4, COORD_MAX));
    c.level_steps = LEVEL_BITS'($urandom_range(0, 1023));
    r = $urandom_range(0, 99);
    if (r < 70) c.debounce = DEB_BITS'($urandom_range(0, 4));
    else if (r < 95) c.debounce = DEB_BITS'($urandom_range(5, 40));
    else c.debounce = DEB_BITS'($urandom_range(41, 65535));
    return c;
  endfunction

  initial begin : stimulus
    tracker_regs_t c;
    int            sent;
    int            n;

    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.object_count = '0;
    in_if.pos_x        = '0;
    in_if.pos_y        = '0;
    cfg_psel           = 1'b0;
    cfg_penable        = 1'b0;
    cfg_pwrite         = 1'b0;
    cfg_paddr          = '0;
    cfg_pwdata         = '0;
    tracker_regs = '{12'd0, 12'd0, 12'd0, 12'd0, 12'd1, 12'd640, 10'd127, 16'd0};
    trk_mode     = MODE_NONE;
    deb_left     = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    load_regs('{12'd100, 12'd2000, 12'd500, 12'd1500, 12'd1000, 12'd640, 10'd127, 16'd2});
    for (int i = 0; i < DIR_ROWS; i++)
      send_frame(dir_rows[i].cnt, dir_rows[i].x, dir_rows[i].y, dir_rows[i].typed,
                 dir_rows[i].res);
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: c = '{12'd0, 12'd0, 12'd0, 12'd0, 12'd1, 12'd640, 10'd127, 16'd0};
        1: c = '{12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 10'd1023,
                 16'd65535};
        2: c = '{12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd4, 10'd0, 16'd0};
        // zero span with the lines wide apart
        3: c = '{12'd2000, 12'd1000, 12'd500, 12'd3000, 12'd0, 12'd640, 10'd1023, 16'd1};
        // low line above high line
        4: c = '{12'd1500, 12'd2500, 12'd3000, 12'd1000, 12'd2000, 12'd3000, 10'd500, 16'd3};
        default: c = rand_regs();
      endcase
      calm = (ph % 4 == 3);
      load_regs(c);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        play_gesture(n);
        sent += n;
      end
      settle();
    end

    if (errors == 0 && pending_results.size() == 0)
      $display("PASS position_zone_gesture_tracker");
    else
      $display("FAIL position_zone_gesture_tracker");
    $finish;
  end

endmodule

FILE: sim.f
sv/pzgt_pkg.sv
sv/pzgt_if.sv
sv/pzgt_div.sv
sv/position_zone_gesture_tracker.sv
sv/pzgt_checker.sv
tb/tb_position_zone_gesture_tracker.sv
